### design/wmc_pkg.sv
// ----------------------------------------------------------------------------
// wmc_pkg
// Types, codes and helpers shared by the word machine core modules.
// ----------------------------------------------------------------------------
package wmc_pkg;

	localparam int MEM_WORDS = 65536;
	localparam int PC_GUARD  = 10;
	localparam int AW        = $clog2(MEM_WORDS);

	// item operations
	localparam logic [2:0] OP_CODE_WR = 3'd0;
	localparam logic [2:0] OP_DATA_WR = 3'd1;
	localparam logic [2:0] OP_RUN     = 3'd2;
	localparam logic [2:0] OP_PORT    = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	// result kinds
	localparam logic [2:0] K_DONE  = 3'd0;
	localparam logic [2:0] K_PWR   = 3'd1;
	localparam logic [2:0] K_PREQ  = 3'd2;
	localparam logic [2:0] K_HALT  = 3'd3;
	localparam logic [2:0] K_READ  = 3'd4;

	// halt causes
	localparam logic [1:0] HC_HALT  = 2'd0;
	localparam logic [1:0] HC_BADOP = 2'd1;
	localparam logic [1:0] HC_PCLIM = 2'd2;

	// operand modes
	localparam logic [1:0] MD_DIR = 2'd0;
	localparam logic [1:0] MD_IMM = 2'd1;
	localparam logic [1:0] MD_STK = 2'd2;
	localparam logic [1:0] MD_USR = 2'd3;

	// opcodes
	localparam logic [7:0] OC_NOP   = 8'h00;
	localparam logic [7:0] OC_MOV   = 8'h01;
	localparam logic [7:0] OC_PUSH  = 8'h02;
	localparam logic [7:0] OC_POP   = 8'h03;
	localparam logic [7:0] OC_SUB   = 8'h04;
	localparam logic [7:0] OC_ADD   = 8'h05;
	localparam logic [7:0] OC_MUL   = 8'h06;
	localparam logic [7:0] OC_DIV   = 8'h07;
	localparam logic [7:0] OC_MOD   = 8'h08;
	localparam logic [7:0] OC_EQ    = 8'h09;
	localparam logic [7:0] OC_NEQ   = 8'h0A;
	localparam logic [7:0] OC_LT    = 8'h0B;
	localparam logic [7:0] OC_GT    = 8'h0C;
	localparam logic [7:0] OC_LTE   = 8'h0D;
	localparam logic [7:0] OC_GTE   = 8'h0E;
	localparam logic [7:0] OC_LAND  = 8'h0F;
	localparam logic [7:0] OC_AND   = 8'h10;
	localparam logic [7:0] OC_OR    = 8'h11;
	localparam logic [7:0] OC_JZ    = 8'h12;
	localparam logic [7:0] OC_RJZ   = 8'h13;
	localparam logic [7:0] OC_OUT   = 8'h14;
	localparam logic [7:0] OC_IN    = 8'h15;
	localparam logic [7:0] OC_SETS  = 8'h16;
	localparam logic [7:0] OC_SETU  = 8'h17;
	localparam logic [7:0] OC_COPY  = 8'h18;
	localparam logic [7:0] OC_PUSHA = 8'h19;
	localparam logic [7:0] OC_POPA  = 8'h1A;
	localparam logic [7:0] OC_BSET  = 8'h1B;
	localparam logic [7:0] OC_BMOVE = 8'h1C;
	localparam logic [7:0] OC_HALT  = 8'hFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] addr;
		logic [15:0] data;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] port;
		logic [15:0] value;
		logic [15:0] pc_now;
		logic [1:0]  halt_cause;
		logic        div_zero;
	} res_t;

	typedef enum logic [2:0] {
		CL_CODE_WR,
		CL_DATA_WR,
		CL_RUN,
		CL_PORT,
		CL_READ,
		CL_NONE
	} cls_t;

	typedef struct packed {
		cls_t  cls;
		item_t item;
	} job_t;

	typedef struct packed {
		logic        start;
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quo;
		logic [15:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_PIN,
		S_FETCH,
		S_DEC,
		S_OPND,
		S_EXEC,
		S_DIV,
		S_BLK,
		S_FIN
	} state_t;

	// number of operands resolved before execution
	function automatic logic [2:0] nopnd(input logic [7:0] oc);
		logic [2:0] n;
		unique case (oc)
			OC_PUSH, OC_POP, OC_SETS, OC_SETU: n = 3'd1;
			OC_MOV, OC_SUB, OC_ADD, OC_MUL, OC_DIV, OC_MOD, OC_EQ, OC_NEQ,
			OC_LT, OC_GT, OC_LTE, OC_GTE, OC_LAND, OC_AND, OC_OR, OC_JZ,
			OC_RJZ, OC_OUT, OC_IN, OC_PUSHA, OC_POPA: n = 3'd2;
			OC_BSET, OC_BMOVE: n = 3'd3;
			OC_COPY: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic mapped(input logic [15:0] a);
		return {1'b0, a} < 17'(MEM_WORDS);
	endfunction

endpackage

### design/wmc_front.sv
// ----------------------------------------------------------------------------
// wmc_front
// Input side: takes items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module wmc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  wmc_pkg::item_t item,
	output logic           job_valid,
	output wmc_pkg::job_t  job,
	input  logic           job_pop
);

	wmc_pkg::job_t fifo_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	wmc_pkg::cls_t cls;

	always_comb begin
		unique case (item.op)
			wmc_pkg::OP_CODE_WR: cls = wmc_pkg::CL_CODE_WR;
			wmc_pkg::OP_DATA_WR: cls = wmc_pkg::CL_DATA_WR;
			wmc_pkg::OP_RUN:     cls = wmc_pkg::CL_RUN;
			wmc_pkg::OP_PORT:    cls = wmc_pkg::CL_PORT;
			wmc_pkg::OP_READ:    cls = wmc_pkg::CL_READ;
			default:             cls = wmc_pkg::CL_NONE;
		endcase
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign job_valid  = (cnt_q != 2'd0);
	assign job        = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{cls: cls, item: item};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (job_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

endmodule

### design/wmc_div.sv
// ----------------------------------------------------------------------------
// wmc_div
// Unsigned 16-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wmc_pkg::div_req_t req,
	output wmc_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [16:0] shifted;
	logic [16:0] diff;
	logic        fits;

	assign shifted = {rem_q, quo_q[15]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], fits};
			rem_q <= fits ? diff[15:0] : shifted[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) busy_q <= 1'b0;
			end
		end
	end

	assign rsp = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule

### design/wmc_back.sv
// ----------------------------------------------------------------------------
// wmc_back
// Execution side: code and data stores, sequencer and result register.
// ----------------------------------------------------------------------------
module wmc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  wmc_pkg::job_t     job,
	output logic              job_pop,
	output wmc_pkg::div_req_t div_req,
	input  wmc_pkg::div_rsp_t div_rsp,
	output logic              res_valid,
	output wmc_pkg::res_t     res,
	input  logic              res_stall
);

	localparam int AW = wmc_pkg::AW;

	logic [15:0] cmem [wmc_pkg::MEM_WORDS];
	logic [15:0] dmem [wmc_pkg::MEM_WORDS];

	// memory ports
	logic        cm_we, dm_we;
	logic [15:0] cm_wa, cm_wd, cm_ra, cm_q, cm_rd;
	logic [15:0] dm_wa, dm_wd, dm_ra, dm_q, rdv;
	logic        cm_map_q, dm_map_q;

	// control state
	wmc_pkg::state_t state_q, state_d;
	logic [2:0]  ph_q, ph_d;
	logic [1:0]  k_q, k_d;
	logic [2:0]  fc_q, fc_d;
	logic [15:0] pc_q, pc_d, ss_q, ss_d, us_q, us_d;
	logic        halted_q, halted_d, await_q, await_d;
	logic [17:0] pdest_q, pdest_d;
	logic [15:0] pport_q, pport_d;
	logic [1:0]  hcode_q, hcode_d;
	logic        ov_q, ov_d;
	logic [AW-1:0] clr_q, clr_d;

	// per-item payload
	wmc_pkg::job_t job_q, job_d;
	wmc_pkg::res_t res_q, res_d;
	logic [15:0] w_q, w_d;
	logic [15:0] a_q [4];
	logic [15:0] a_d [4];
	logic [15:0] v_q [4];
	logic [15:0] v_d [4];
	logic [15:0] ea_q [4];
	logic [15:0] ea_d [4];
	logic [3:0]  wok_q, wok_d;
	logic [15:0] t_q, t_d;
	logic [2:0]  kind_q, kind_d;
	logic [15:0] port_q, port_d, val_q, val_d;
	logic        dz_q, dz_d;
	logic [16:0] i_q, i_d;
	logic        dir_q, dir_d;

	// decode and datapath helpers
	logic [7:0]  oc;
	logic [1:0]  md [4];
	logic [15:0] p1, np, sum01, sum23, cur_x, pin_x;
	logic [1:0]  cur_m, pin_m;
	logic [2:0]  nop_n;
	logic        opnd_last, adv, fin;
	logic [31:0] mul32;
	logic [16:0] bn, bidx;
	logic [17:0] bdi, bsi;
	logic        bmore, bd_ok, bs_ok;

	assign oc        = w_q[7:0];
	assign md[0]     = w_q[15:14];
	assign md[1]     = w_q[13:12];
	assign md[2]     = w_q[11:10];
	assign md[3]     = w_q[9:8];
	assign p1        = pc_q + 16'd1;
	assign nop_n     = wmc_pkg::nopnd(oc);
	assign opnd_last = (k_q == 2'(nop_n - 3'd1));
	assign cur_m     = md[k_q];
	assign cur_x     = a_q[k_q];
	assign pin_m     = pdest_q[17:16];
	assign pin_x     = pdest_q[15:0];
	assign sum01     = v_q[0] + v_q[1];
	assign sum23     = v_q[2] + v_q[3];
	assign mul32     = v_q[0] * v_q[1];
	assign bn        = {1'b0, v_q[2]};
	assign bidx      = dir_q ? (i_q - 17'd1) : i_q;
	assign bmore     = dir_q ? (i_q != 17'd0) : (i_q < bn);
	assign bdi       = {2'b0, v_q[0]} + {1'b0, bidx};
	assign bsi       = {2'b0, v_q[1]} + {1'b0, bidx};
	assign bd_ok     = bdi < 18'(wmc_pkg::MEM_WORDS);
	assign bs_ok     = bsi < 18'(wmc_pkg::MEM_WORDS);
	assign cm_rd     = cm_map_q ? cm_q : '0;
	assign rdv       = dm_map_q ? dm_q : '0;

	// stores: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		if (cm_we && wmc_pkg::mapped(cm_wa)) cmem[cm_wa[AW-1:0]] <= cm_wd;
		cm_q     <= cmem[cm_ra[AW-1:0]];
		cm_map_q <= wmc_pkg::mapped(cm_ra);
		if (dm_we && wmc_pkg::mapped(dm_wa)) dmem[dm_wa[AW-1:0]] <= dm_wd;
		dm_q     <= dmem[dm_ra[AW-1:0]];
		dm_map_q <= wmc_pkg::mapped(dm_ra);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wmc_pkg::S_CLR;
			ph_q     <= '0;
			k_q      <= '0;
			fc_q     <= '0;
			pc_q     <= '0;
			ss_q     <= '0;
			us_q     <= '0;
			halted_q <= 1'b0;
			await_q  <= 1'b0;
			pdest_q  <= '0;
			pport_q  <= '0;
			hcode_q  <= '0;
			ov_q     <= 1'b0;
			clr_q    <= '0;
		end else begin
			state_q  <= state_d;
			ph_q     <= ph_d;
			k_q      <= k_d;
			fc_q     <= fc_d;
			pc_q     <= pc_d;
			ss_q     <= ss_d;
			us_q     <= us_d;
			halted_q <= halted_d;
			await_q  <= await_d;
			pdest_q  <= pdest_d;
			pport_q  <= pport_d;
			hcode_q  <= hcode_d;
			ov_q     <= ov_d;
			clr_q    <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		job_q  <= job_d;
		res_q  <= res_d;
		w_q    <= w_d;
		a_q    <= a_d;
		v_q    <= v_d;
		ea_q   <= ea_d;
		wok_q  <= wok_d;
		t_q    <= t_d;
		kind_q <= kind_d;
		port_q <= port_d;
		val_q  <= val_d;
		dz_q   <= dz_d;
		i_q    <= i_d;
		dir_q  <= dir_d;
	end

	always_comb begin
		state_d  = state_q;
		ph_d     = ph_q;
		k_d      = k_q;
		fc_d     = fc_q;
		pc_d     = pc_q;
		ss_d     = ss_q;
		us_d     = us_q;
		halted_d = halted_q;
		await_d  = await_q;
		pdest_d  = pdest_q;
		pport_d  = pport_q;
		hcode_d  = hcode_q;
		ov_d     = ov_q;
		clr_d    = clr_q;
		job_d    = job_q;
		res_d    = res_q;
		w_d      = w_q;
		a_d      = a_q;
		v_d      = v_q;
		ea_d     = ea_q;
		wok_d    = wok_q;
		t_d      = t_q;
		kind_d   = kind_q;
		port_d   = port_q;
		val_d    = val_q;
		dz_d     = dz_q;
		i_d      = i_q;
		dir_d    = dir_q;
		job_pop  = 1'b0;
		cm_we    = 1'b0;
		cm_wa    = job_q.item.addr;
		cm_wd    = job_q.item.data;
		cm_ra    = pc_q + 16'(fc_q);
		dm_we    = 1'b0;
		dm_wa    = '0;
		dm_wd    = '0;
		dm_ra    = '0;
		div_req  = '{start: 1'b0, num: v_q[0], den: v_q[1]};
		adv      = 1'b0;
		fin      = 1'b0;
		np       = p1 + 16'd2;

		if (ov_q && !res_stall) ov_d = 1'b0;

		unique case (state_q)
			wmc_pkg::S_CLR: begin
				cm_we = 1'b1;
				dm_we = 1'b1;
				cm_wa = 16'(clr_q);
				cm_wd = '0;
				dm_wa = 16'(clr_q);
				dm_wd = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == AW'(wmc_pkg::MEM_WORDS - 1)) state_d = wmc_pkg::S_IDLE;
			end
			wmc_pkg::S_IDLE: begin
				if (job_valid && !ov_q) begin
					job_pop = 1'b1;
					job_d   = job;
					kind_d  = wmc_pkg::K_DONE;
					port_d  = '0;
					val_d   = '0;
					dz_d    = 1'b0;
					ph_d    = '0;
					k_d     = '0;
					fc_d    = '0;
					state_d = wmc_pkg::S_FIN;
					unique case (job.cls)
						wmc_pkg::CL_CODE_WR: begin
							cm_we = 1'b1;
							cm_wa = job.item.addr;
							cm_wd = job.item.data;
						end
						wmc_pkg::CL_DATA_WR: begin
							dm_we = 1'b1;
							dm_wa = job.item.addr;
							dm_wd = job.item.data;
						end
						wmc_pkg::CL_READ: begin
							dm_ra   = job.item.addr;
							state_d = wmc_pkg::S_RD;
						end
						wmc_pkg::CL_PORT: begin
							if (halted_q) kind_d = wmc_pkg::K_HALT;
							if (await_q) state_d = wmc_pkg::S_PIN;
						end
						wmc_pkg::CL_RUN: begin
							if (halted_q) begin
								kind_d = wmc_pkg::K_HALT;
							end else if (await_q) begin
								kind_d = wmc_pkg::K_PREQ;
								port_d = pport_q;
							end else begin
								state_d = wmc_pkg::S_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			wmc_pkg::S_RD: begin
				kind_d  = wmc_pkg::K_READ;
				val_d   = rdv;
				state_d = wmc_pkg::S_FIN;
			end
			wmc_pkg::S_PIN: begin
				if (ph_q == 3'd0) begin
					priority case (pin_m)
						wmc_pkg::MD_DIR: begin
							dm_we   = 1'b1;
							dm_wa   = pin_x;
							dm_wd   = job_q.item.data;
							await_d = 1'b0;
							state_d = wmc_pkg::S_FIN;
						end
						wmc_pkg::MD_IMM: begin
							await_d = 1'b0;
							state_d = wmc_pkg::S_FIN;
						end
						default: begin
							dm_ra = (pin_m == wmc_pkg::MD_STK) ? ss_q : us_q;
							ph_d  = 3'd1;
						end
					endcase
				end else begin
					dm_we   = 1'b1;
					dm_wa   = rdv + pin_x;
					dm_wd   = job_q.item.data;
					await_d = 1'b0;
					state_d = wmc_pkg::S_FIN;
				end
			end
			wmc_pkg::S_FETCH: begin
				// word f-1 arrives while fc is f
				fc_d = fc_q + 3'd1;
				if (fc_q == 3'd1) w_d = cm_rd;
				if (fc_q >= 3'd2) a_d[2'(fc_q - 3'd2)] = cm_rd;
				if (fc_q == 3'd5) begin
					ph_d = '0;
					k_d  = '0;
					if (oc == wmc_pkg::OC_PUSHA) state_d = wmc_pkg::S_DEC;
					else if (nop_n == 3'd0) state_d = wmc_pkg::S_EXEC;
					else state_d = wmc_pkg::S_OPND;
				end
			end
			wmc_pkg::S_DEC: begin
				// push-from-address drops the stack pointer before its operands
				if (ph_q == 3'd0) begin
					dm_ra = ss_q;
					ph_d  = 3'd1;
				end else begin
					dm_we   = 1'b1;
					dm_wa   = ss_q;
					dm_wd   = rdv - 16'd1;
					ph_d    = '0;
					state_d = wmc_pkg::S_OPND;
				end
			end
			wmc_pkg::S_OPND: begin
				unique case (ph_q)
					3'd0: begin
						ea_d[k_q]  = cur_x;
						wok_d[k_q] = (cur_m != wmc_pkg::MD_IMM);
						priority case (cur_m)
							wmc_pkg::MD_IMM: begin
								v_d[k_q] = cur_x;
								adv      = 1'b1;
							end
							wmc_pkg::MD_DIR: begin
								dm_ra = cur_x;
								ph_d  = 3'd2;
							end
							default: begin
								dm_ra = (cur_m == wmc_pkg::MD_STK) ? ss_q : us_q;
								ph_d  = 3'd1;
							end
						endcase
					end
					3'd1: begin
						ea_d[k_q] = rdv + cur_x;
						dm_ra     = rdv + cur_x;
						ph_d      = 3'd2;
					end
					default: begin
						v_d[k_q] = rdv;
						adv      = 1'b1;
					end
				endcase
				if (adv) begin
					ph_d = '0;
					if (opnd_last) state_d = wmc_pkg::S_EXEC;
					else k_d = k_q + 2'd1;
				end
			end
			wmc_pkg::S_EXEC: begin
				ph_d = ph_q + 3'd1;
				unique case (oc)
					wmc_pkg::OC_NOP: begin
						np  = p1;
						fin = 1'b1;
					end
					wmc_pkg::OC_MOV: begin
						dm_we = wok_q[0];
						dm_wa = ea_q[0];
						dm_wd = v_q[1];
						fin   = 1'b1;
					end
					wmc_pkg::OC_PUSH: begin
						np = p1 + 16'd1;
						unique case (ph_q)
							3'd0, 3'd2: dm_ra = ss_q;
							3'd1: begin
								dm_we = 1'b1;
								dm_wa = ss_q;
								dm_wd = rdv - 16'd1;
							end
							default: begin
								dm_we = 1'b1;
								dm_wa = rdv;
								dm_wd = v_q[0];
								fin   = 1'b1;
							end
						endcase
					end
					wmc_pkg::OC_POP, wmc_pkg::OC_POPA: begin
						if (oc == wmc_pkg::OC_POP) np = p1 + 16'd1;
						unique case (ph_q)
							3'd0, 3'd3: dm_ra = ss_q;
							3'd1: dm_ra = rdv;
							3'd2: begin
								dm_we = (oc == wmc_pkg::OC_POP) ? wok_q[0] : 1'b1;
								dm_wa = (oc == wmc_pkg::OC_POP) ? ea_q[0] : sum01;
								dm_wd = rdv;
							end
							default: begin
								dm_we = 1'b1;
								dm_wa = ss_q;
								dm_wd = rdv + 16'd1;
								fin   = 1'b1;
							end
						endcase
					end
					wmc_pkg::OC_SUB, wmc_pkg::OC_ADD, wmc_pkg::OC_MUL, wmc_pkg::OC_DIV,
					wmc_pkg::OC_MOD, wmc_pkg::OC_EQ, wmc_pkg::OC_NEQ, wmc_pkg::OC_LT,
					wmc_pkg::OC_GT, wmc_pkg::OC_LTE, wmc_pkg::OC_GTE, wmc_pkg::OC_LAND,
					wmc_pkg::OC_AND, wmc_pkg::OC_OR: begin
						if (ph_q == 3'd0) begin
							unique case (oc)
								wmc_pkg::OC_SUB:  t_d = v_q[0] - v_q[1];
								wmc_pkg::OC_ADD:  t_d = v_q[0] + v_q[1];
								wmc_pkg::OC_MUL:  t_d = mul32[15:0];
								wmc_pkg::OC_EQ:   t_d = {15'd0, v_q[0] == v_q[1]};
								wmc_pkg::OC_NEQ:  t_d = {15'd0, v_q[0] != v_q[1]};
								wmc_pkg::OC_LT:   t_d = {15'd0, v_q[0] < v_q[1]};
								wmc_pkg::OC_GT:   t_d = {15'd0, v_q[0] > v_q[1]};
								wmc_pkg::OC_LTE:  t_d = {15'd0, v_q[0] <= v_q[1]};
								wmc_pkg::OC_GTE:  t_d = {15'd0, v_q[0] >= v_q[1]};
								wmc_pkg::OC_LAND: t_d = {15'd0, (v_q[0] != '0) && (v_q[1] != '0)};
								wmc_pkg::OC_AND:  t_d = v_q[0] & v_q[1];
								wmc_pkg::OC_OR:   t_d = v_q[0] | v_q[1];
								default: begin
									// divide and modulo
									if (v_q[1] == '0) begin
										t_d  = (oc == wmc_pkg::OC_DIV) ? 16'hFFFF : v_q[0];
										dz_d = 1'b1;
									end else begin
										div_req.start = 1'b1;
										state_d       = wmc_pkg::S_DIV;
									end
								end
							endcase
						end else begin
							dm_we = wok_q[0];
							dm_wa = ea_q[0];
							dm_wd = t_q;
							fin   = 1'b1;
						end
					end
					wmc_pkg::OC_JZ: begin
						if (v_q[1] == '0) np = v_q[0];
						fin = 1'b1;
					end
					wmc_pkg::OC_RJZ: begin
						if (v_q[1] == '0) np = p1 + v_q[0];
						fin = 1'b1;
					end
					wmc_pkg::OC_OUT: begin
						kind_d = wmc_pkg::K_PWR;
						port_d = v_q[0];
						val_d  = v_q[1];
						fin    = 1'b1;
					end
					wmc_pkg::OC_IN: begin
						pport_d = v_q[1];
						pdest_d = {md[0], a_q[0]};
						await_d = 1'b1;
						kind_d  = wmc_pkg::K_PREQ;
						port_d  = v_q[1];
						fin     = 1'b1;
					end
					wmc_pkg::OC_SETS: begin
						ss_d = v_q[0];
						np   = p1 + 16'd1;
						fin  = 1'b1;
					end
					wmc_pkg::OC_SETU: begin
						us_d = v_q[0];
						np   = p1 + 16'd1;
						fin  = 1'b1;
					end
					wmc_pkg::OC_COPY: begin
						np = p1 + 16'd4;
						if (ph_q == 3'd0) begin
							dm_ra = sum23;
						end else begin
							dm_we = 1'b1;
							dm_wa = sum01;
							dm_wd = rdv;
							fin   = 1'b1;
						end
					end
					wmc_pkg::OC_PUSHA: begin
						unique case (ph_q)
							3'd0: dm_ra = sum01;
							3'd1: begin
								t_d   = rdv;
								dm_ra = ss_q;
							end
							default: begin
								dm_we = 1'b1;
								dm_wa = rdv;
								dm_wd = t_q;
								fin   = 1'b1;
							end
						endcase
					end
					wmc_pkg::OC_BSET, wmc_pkg::OC_BMOVE: begin
						// a move copies downward when the source lies below the target
						dir_d   = (oc == wmc_pkg::OC_BMOVE) && (v_q[1] < v_q[0]);
						i_d     = ((oc == wmc_pkg::OC_BMOVE) && (v_q[1] < v_q[0])) ? bn : '0;
						ph_d    = '0;
						state_d = wmc_pkg::S_BLK;
					end
					default: begin
						// halt and unknown opcodes
						pc_d     = p1;
						halted_d = 1'b1;
						hcode_d  = (oc == wmc_pkg::OC_HALT) ? wmc_pkg::HC_HALT : wmc_pkg::HC_BADOP;
						kind_d   = wmc_pkg::K_HALT;
						state_d  = wmc_pkg::S_FIN;
					end
				endcase
			end
			wmc_pkg::S_DIV: begin
				if (div_rsp.done) begin
					t_d     = (oc == wmc_pkg::OC_DIV) ? div_rsp.quo : div_rsp.rem;
					ph_d    = 3'd1;
					state_d = wmc_pkg::S_EXEC;
				end
			end
			wmc_pkg::S_BLK: begin
				np = p1 + 16'd3;
				if (oc == wmc_pkg::OC_BSET) begin
					if (bmore && bd_ok) begin
						dm_we = 1'b1;
						dm_wa = bdi[15:0];
						dm_wd = v_q[1];
						i_d   = i_q + 17'd1;
					end else begin
						fin = 1'b1;
					end
				end else if (ph_q == 3'd0) begin
					if (!bmore) begin
						fin = 1'b1;
					end else if (bd_ok && bs_ok) begin
						dm_ra = bsi[15:0];
						ph_d  = 3'd1;
					end else begin
						i_d = dir_q ? (i_q - 17'd1) : (i_q + 17'd1);
					end
				end else begin
					dm_we = 1'b1;
					dm_wa = bdi[15:0];
					dm_wd = rdv;
					i_d   = dir_q ? (i_q - 17'd1) : (i_q + 17'd1);
					ph_d  = '0;
				end
			end
			wmc_pkg::S_FIN: begin
				res_d = '{kind: kind_q, port: port_q, value: val_q, pc_now: pc_q,
					halt_cause: (kind_q == wmc_pkg::K_HALT) ? hcode_q : 2'd0,
					div_zero: dz_q};
				ov_d    = 1'b1;
				state_d = wmc_pkg::S_IDLE;
			end
			default: state_d = wmc_pkg::S_IDLE;
		endcase

		// retire: advance pc and check the guard band at the top of memory
		if (fin) begin
			pc_d    = np;
			state_d = wmc_pkg::S_FIN;
			if (18'(np) + 18'(wmc_pkg::PC_GUARD) >= 18'(wmc_pkg::MEM_WORDS)) begin
				halted_d = 1'b1;
				hcode_d  = wmc_pkg::HC_PCLIM;
				if (kind_d == wmc_pkg::K_DONE) kind_d = wmc_pkg::K_HALT;
			end
		end
	end

	assign res_valid = ov_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag dropped");

	a_cause_only_on_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && res_q.kind != wmc_pkg::K_HALT) |-> (res_q.halt_cause == 2'd0))
		else $error("halt cause on a non-halt result");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (state_q == wmc_pkg::S_IDLE && !ov_q && job_valid))
		else $error("transaction taken while busy");

	a_await_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(await_q) |-> (state_q == wmc_pkg::S_FIN && kind_q == wmc_pkg::K_PREQ))
		else $error("port wait set without a request");
`endif

endmodule

### design/word_machine_cpu_core.sv
// ----------------------------------------------------------------------------
// word_machine_cpu_core
// 16-bit memory-to-memory processor with code and data stores and port I/O.
// ----------------------------------------------------------------------------
// After reset the core sweeps both stores to zero, one word of each per
// cycle; items queue in the two-entry input buffer but none is executed
// until the sweep ends. Items then run one at a time through the
// sequencer, which owns a single read and a single write port on each
// store: a run item passes through fetch and retire, the resolution of
// each operand (direct, immediate or pointer-relative) and the execute
// steps of arithmetic, stack or memory traffic (push from address first
// lowers the stack pointer); divide and modulo by a nonzero divisor wait
// on the bit-serial divider, block set writes one word per step and block
// move reads and then writes each word.
module word_machine_cpu_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  wmc_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_stall,
	output wmc_pkg::res_t  res
);

	logic              job_valid;
	logic              job_pop;
	wmc_pkg::job_t     job;
	wmc_pkg::div_req_t div_req;
	wmc_pkg::div_rsp_t div_rsp;

	wmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop)
	);

	wmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

endmodule

### tb/tb_word_machine_cpu_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_machine_cpu_core
// Self-checking bench for the word machine core: a directed table (loads,
// extremes, division by zero, port traffic) followed by random instruction
// streams, each result compared against a cycle-free instruction-level model.
// ----------------------------------------------------------------------------
module tb_word_machine_cpu_core;

	localparam int N_ITEMS  = 1500;
	localparam int WD_LIMIT = 400000;

	typedef struct {
		wmc_pkg::item_t it;
		bit             chk;
		wmc_pkg::res_t  exp;
	} row_t;

	logic           clk;
	logic           arst_n;
	logic           item_valid;
	logic           item_stall;
	wmc_pkg::item_t item;
	logic           res_valid;
	logic           res_stall;
	wmc_pkg::res_t  res;

	// shadow machine state
	bit [15:0] code_mem [wmc_pkg::MEM_WORDS];
	bit [15:0] dat_mem  [wmc_pkg::MEM_WORDS];
	bit [15:0] m_pc, m_sslot, m_uslot, m_pport;
	bit [17:0] m_pdest;
	bit        m_halted, m_await;
	bit [1:0]  m_hcause;

	wmc_pkg::res_t expected_q [$];
	row_t rows [$];
	int   n_err, n_sent, n_recv, n_divz, n_pwr, n_preq, n_insn;
	int   snd_idle, rcv_idle, hold_left, idle_cnt;
	bit   hold_req, acc_any;

	word_machine_cpu_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit [15:0] ld_word(bit [15:0] a);
		return dat_mem[a];
	endfunction

	function automatic void st_word(bit [15:0] a, bit [15:0] v);
		dat_mem[a] = v;
	endfunction

	function automatic bit [15:0] operand_value(bit [1:0] md, bit [15:0] x);
		case (md)
			wmc_pkg::MD_DIR: return ld_word(x);
			wmc_pkg::MD_IMM: return x;
			wmc_pkg::MD_STK: return ld_word(ld_word(m_sslot) + x);
			default: return ld_word(ld_word(m_uslot) + x);
		endcase
	endfunction

	function automatic void operand_store(bit [1:0] md, bit [15:0] x, bit [15:0] v);
		case (md)
			wmc_pkg::MD_DIR: st_word(x, v);
			wmc_pkg::MD_IMM: ;
			wmc_pkg::MD_STK: st_word(ld_word(m_sslot) + x, v);
			default: st_word(ld_word(m_uslot) + x, v);
		endcase
	endfunction

	function automatic void execute_insn(ref wmc_pkg::res_t r);
		bit [15:0] w, p1, x, y, v, a0, a1, a2, a3;
		bit [7:0]  oc;
		bit [1:0]  m0, m1, m2, m3;
		int        np, d, s, n, i;
		w  = code_mem[m_pc];
		p1 = m_pc + 16'd1;
		oc = w[7:0];
		m0 = w[15:14]; m1 = w[13:12]; m2 = w[11:10]; m3 = w[9:8];
		a0 = code_mem[p1]; a1 = code_mem[16'(p1 + 1)];
		a2 = code_mem[16'(p1 + 2)]; a3 = code_mem[16'(p1 + 3)];
		np = p1 + 2;
		v  = 16'd0;
		case (oc)
			wmc_pkg::OC_NOP: np = p1;
			wmc_pkg::OC_MOV: operand_store(m0, a0, operand_value(m1, a1));
			wmc_pkg::OC_PUSH: begin
				x = operand_value(m0, a0);
				st_word(m_sslot, ld_word(m_sslot) - 16'd1);
				st_word(ld_word(m_sslot), x);
				np = p1 + 1;
			end
			wmc_pkg::OC_POP: begin
				operand_store(m0, a0, ld_word(ld_word(m_sslot)));
				st_word(m_sslot, ld_word(m_sslot) + 16'd1);
				np = p1 + 1;
			end
			wmc_pkg::OC_SUB, wmc_pkg::OC_ADD, wmc_pkg::OC_MUL, wmc_pkg::OC_DIV,
			wmc_pkg::OC_MOD, wmc_pkg::OC_EQ, wmc_pkg::OC_NEQ, wmc_pkg::OC_LT,
			wmc_pkg::OC_GT, wmc_pkg::OC_LTE, wmc_pkg::OC_GTE, wmc_pkg::OC_LAND,
			wmc_pkg::OC_AND, wmc_pkg::OC_OR: begin
				x = operand_value(m0, a0);
				y = operand_value(m1, a1);
				case (oc)
					wmc_pkg::OC_SUB: v = x - y;
					wmc_pkg::OC_ADD: v = x + y;
					wmc_pkg::OC_MUL: v = x * y;
					wmc_pkg::OC_DIV: begin
						if (y == 0) begin
							v = 16'hFFFF; r.div_zero = 1'b1;
						end else v = x / y;
					end
					wmc_pkg::OC_MOD: begin
						if (y == 0) begin
							v = x; r.div_zero = 1'b1;
						end else v = x % y;
					end
					wmc_pkg::OC_EQ:   v = 16'(x == y);
					wmc_pkg::OC_NEQ:  v = 16'(x != y);
					wmc_pkg::OC_LT:   v = 16'(x < y);
					wmc_pkg::OC_GT:   v = 16'(x > y);
					wmc_pkg::OC_LTE:  v = 16'(x <= y);
					wmc_pkg::OC_GTE:  v = 16'(x >= y);
					wmc_pkg::OC_LAND: v = 16'((x != 0) && (y != 0));
					wmc_pkg::OC_AND:  v = x & y;
					default: v = x | y;
				endcase
				operand_store(m0, a0, v);
			end
			wmc_pkg::OC_JZ: if (operand_value(m1, a1) == 0) np = operand_value(m0, a0);
			wmc_pkg::OC_RJZ: if (operand_value(m1, a1) == 0) np = p1 + operand_value(m0, a0);
			wmc_pkg::OC_OUT: begin
				r.kind  = wmc_pkg::K_PWR;
				r.port  = operand_value(m0, a0);
				r.value = operand_value(m1, a1);
			end
			wmc_pkg::OC_IN: begin
				m_pport = operand_value(m1, a1);
				m_pdest = {m0, a0};
				m_await = 1'b1;
				r.kind  = wmc_pkg::K_PREQ;
				r.port  = m_pport;
			end
			wmc_pkg::OC_SETS: begin
				m_sslot = operand_value(m0, a0); np = p1 + 1;
			end
			wmc_pkg::OC_SETU: begin
				m_uslot = operand_value(m0, a0); np = p1 + 1;
			end
			wmc_pkg::OC_COPY: begin
				x = operand_value(m0, a0) + operand_value(m1, a1);
				y = operand_value(m2, a2) + operand_value(m3, a3);
				st_word(x, ld_word(y));
				np = p1 + 4;
			end
			wmc_pkg::OC_PUSHA: begin
				st_word(m_sslot, ld_word(m_sslot) - 16'd1);
				x = ld_word(operand_value(m0, a0) + operand_value(m1, a1));
				st_word(ld_word(m_sslot), x);
			end
			wmc_pkg::OC_POPA: begin
				st_word(operand_value(m0, a0) + operand_value(m1, a1),
					ld_word(ld_word(m_sslot)));
				st_word(m_sslot, ld_word(m_sslot) + 16'd1);
			end
			wmc_pkg::OC_BSET: begin
				d = operand_value(m0, a0);
				x = operand_value(m1, a1);
				n = operand_value(m2, a2);
				for (i = 0; i < n && d + i < wmc_pkg::MEM_WORDS; i++) dat_mem[d + i] = x;
				np = p1 + 3;
			end
			wmc_pkg::OC_BMOVE: begin
				d = operand_value(m0, a0);
				s = operand_value(m1, a1);
				n = operand_value(m2, a2);
				// copy downward when source is below destination
				if (s < d) begin
					for (i = n - 1; i >= 0; i--)
						if (s + i < wmc_pkg::MEM_WORDS && d + i < wmc_pkg::MEM_WORDS)
							dat_mem[d + i] = dat_mem[s + i];
				end else begin
					for (i = 0; i < n; i++)
						if (s + i < wmc_pkg::MEM_WORDS && d + i < wmc_pkg::MEM_WORDS)
							dat_mem[d + i] = dat_mem[s + i];
				end
				np = p1 + 3;
			end
			wmc_pkg::OC_HALT: begin
				m_pc = p1; m_halted = 1'b1; m_hcause = wmc_pkg::HC_HALT;
				r.kind = wmc_pkg::K_HALT;
				return;
			end
			default: begin
				m_pc = p1; m_halted = 1'b1; m_hcause = wmc_pkg::HC_BADOP;
				r.kind = wmc_pkg::K_HALT;
				return;
			end
		endcase
		m_pc = 16'(np);
		if (int'(m_pc) + wmc_pkg::PC_GUARD >= wmc_pkg::MEM_WORDS) begin
			m_halted = 1'b1;
			m_hcause = wmc_pkg::HC_PCLIM;
			if (r.kind == wmc_pkg::K_DONE) r.kind = wmc_pkg::K_HALT;
		end
	endfunction

	function automatic wmc_pkg::res_t model_item(wmc_pkg::item_t it);
		wmc_pkg::res_t r;
		r = '0;
		case (it.op)
			wmc_pkg::OP_CODE_WR: code_mem[it.addr] = it.data;
			wmc_pkg::OP_DATA_WR: st_word(it.addr, it.data);
			wmc_pkg::OP_RUN: begin
				if (m_halted) r.kind = wmc_pkg::K_HALT;
				else if (m_await) begin
					r.kind = wmc_pkg::K_PREQ; r.port = m_pport;
				end else begin
					execute_insn(r);
					n_insn++;
				end
			end
			wmc_pkg::OP_PORT: begin
				if (m_await) begin
					operand_store(m_pdest[17:16], m_pdest[15:0], it.data);
					m_await = 1'b0;
				end
				if (m_halted) r.kind = wmc_pkg::K_HALT;
			end
			wmc_pkg::OP_READ: begin
				r.kind = wmc_pkg::K_READ; r.value = ld_word(it.addr);
			end
			default: ;
		endcase
		r.pc_now = m_pc;
		if (r.kind == wmc_pkg::K_HALT) r.halt_cause = m_hcause;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR @%0t result %0d: %s got %h expected %h", $realtime, n_recv, what,
			got, want);
		n_err++;
	endtask

	// drive one transaction and hold it until accepted; valid stays high
	// afterwards so that back-to-back transactions need no extra edge
	task automatic send_item(wmc_pkg::item_t it, bit chk = 0, wmc_pkg::res_t want = '0);
		wmc_pkg::res_t r;
		while ($urandom_range(99) < snd_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		r = model_item(it);
		if (chk && r != want) report_mismatch("typed-in expectation", r, want);
		expected_q.push_back(r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic load_code(bit [15:0] a, bit [15:0] w);
		wmc_pkg::item_t it;
		it.op = wmc_pkg::OP_CODE_WR; it.addr = a; it.data = w;
		send_item(it);
	endtask

	task automatic run_step();
		wmc_pkg::item_t it;
		it.op = wmc_pkg::OP_RUN; it.addr = 16'($urandom); it.data = 16'($urandom);
		send_item(it);
	endtask

	function automatic bit [15:0] pick_operand();
		int k;
		k = $urandom_range(99);
		if (k < 55) return 16'($urandom_range(63));
		if (k < 70) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	// write one random instruction at the current pc, then run it
	task automatic random_insn();
		bit [7:0]  oc;
		bit [1:0]  md [4];
		bit [15:0] a [4];
		bit [15:0] pc0;
		int        k;
		oc = 8'($urandom_range(wmc_pkg::OC_BMOVE));
		for (k = 0; k < 4; k++) begin
			md[k] = 2'($urandom);
			a[k]  = pick_operand();
		end
		// keep control flow well below the pc guard and bound block lengths
		if (oc == wmc_pkg::OC_JZ) begin
			md[0] = wmc_pkg::MD_IMM; a[0] = 16'($urandom_range(16'h7000));
		end else if (oc == wmc_pkg::OC_RJZ) begin
			md[0] = wmc_pkg::MD_IMM; a[0] = 16'($urandom_range(64));
		end else if (oc == wmc_pkg::OC_BSET || oc == wmc_pkg::OC_BMOVE) begin
			md[2] = wmc_pkg::MD_IMM;
			a[2]  = ($urandom_range(39) == 0) ? 16'($urandom_range(3000))
				: 16'($urandom_range(40));
		end
		pc0 = m_pc;
		load_code(pc0, {md[0], md[1], md[2], md[3], oc});
		for (k = 0; k < 4; k++) load_code(pc0 + 16'(k + 1), a[k]);
		run_step();
	endtask

	task automatic random_misc();
		wmc_pkg::item_t it;
		int             k;
		k = $urandom_range(99);
		it.addr = ($urandom_range(1)) ? 16'($urandom_range(63)) : 16'($urandom);
		it.data = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
		if (k < 40) it.op = wmc_pkg::OP_DATA_WR;
		else if (k < 75) it.op = wmc_pkg::OP_READ;
		else if (k < 88) it.op = wmc_pkg::OP_PORT;
		else it.op = 3'($urandom_range(5, 7));
		send_item(it);
	endtask

	task automatic add_row(bit [2:0] op, bit [15:0] a, bit [15:0] d, bit chk = 0,
		wmc_pkg::res_t want = '0);
		row_t rw;
		rw.it.op = op; rw.it.addr = a; rw.it.data = d;
		rw.chk = chk; rw.exp = want;
		rows.push_back(rw);
	endtask

	// receiver: random stall, plus one long hold on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		wmc_pkg::res_t want;
		acc_any = (item_valid && !item_stall) || (res_valid && !res_stall);
		if (res_valid && !res_stall) begin
			n_recv++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", res, 0);
			end else begin
				want = expected_q.pop_front();
				if (res.kind != want.kind) report_mismatch("kind", res.kind, want.kind);
				if (res.port != want.port) report_mismatch("port", res.port, want.port);
				if (res.value != want.value) report_mismatch("value", res.value, want.value);
				if (res.pc_now != want.pc_now)
					report_mismatch("pc_now", res.pc_now, want.pc_now);
				if (res.halt_cause != want.halt_cause)
					report_mismatch("halt_cause", res.halt_cause, want.halt_cause);
				if (res.div_zero != want.div_zero)
					report_mismatch("div_zero", res.div_zero, want.div_zero);
				if (want.div_zero) n_divz++;
				if (want.kind == wmc_pkg::K_PWR) n_pwr++;
				if (want.kind == wmc_pkg::K_PREQ) n_preq++;
			end
		end
		idle_cnt = acc_any ? 0 : idle_cnt + 1;
		if (idle_cnt >= WD_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WD_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		wmc_pkg::res_t want;
		bit [15:0]     tail_pc;
		int            v;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		snd_idle   = 25;
		rcv_idle   = 57;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		want = '0; want.kind = wmc_pkg::K_READ;
		add_row(wmc_pkg::OP_READ, 16'h0000, 16'h0000, 1, want);
		add_row(wmc_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 1, want);
		add_row(wmc_pkg::OP_DATA_WR, 16'hFFFF, 16'hFFFF);
		add_row(wmc_pkg::OP_READ, 16'hFFFF, 16'h0000);
		add_row(wmc_pkg::OP_DATA_WR, 16'h0010, 16'h1234);
		want = '0;
		add_row(wmc_pkg::OP_PORT, 16'h0000, 16'h5555, 1, want);   // port data not awaited
		add_row(3'd5, 16'hFFFF, 16'hFFFF, 1, want);
		add_row(3'd7, 16'h0000, 16'h0000, 1, want);
		// div by zero, mod by zero, in, out at pc 0..11
		add_row(wmc_pkg::OP_CODE_WR, 16'd0,
			{wmc_pkg::MD_DIR, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_DIV});
		add_row(wmc_pkg::OP_CODE_WR, 16'd1, 16'h0010);
		add_row(wmc_pkg::OP_CODE_WR, 16'd2, 16'h0000);
		add_row(wmc_pkg::OP_CODE_WR, 16'd3,
			{wmc_pkg::MD_DIR, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_MOD});
		add_row(wmc_pkg::OP_CODE_WR, 16'd4, 16'h0010);
		add_row(wmc_pkg::OP_CODE_WR, 16'd6,
			{wmc_pkg::MD_DIR, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_IN});
		add_row(wmc_pkg::OP_CODE_WR, 16'd7, 16'h0020);
		add_row(wmc_pkg::OP_CODE_WR, 16'd8, 16'hFFFF);
		add_row(wmc_pkg::OP_CODE_WR, 16'd9,
			{wmc_pkg::MD_IMM, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_OUT});
		add_row(wmc_pkg::OP_CODE_WR, 16'd10, 16'hFFFF);
		add_row(wmc_pkg::OP_CODE_WR, 16'd11, 16'hFFFF);
		add_row(wmc_pkg::OP_RUN, 16'h0000, 16'h0000);
		add_row(wmc_pkg::OP_RUN, 16'h0000, 16'h0000);
		add_row(wmc_pkg::OP_RUN, 16'h0000, 16'h0000);
		add_row(wmc_pkg::OP_RUN, 16'h0000, 16'h0000);             // re-issued request
		add_row(wmc_pkg::OP_PORT, 16'h0000, 16'hABCD);
		add_row(wmc_pkg::OP_READ, 16'h0020, 16'h0000);
		add_row(wmc_pkg::OP_RUN, 16'h0000, 16'h0000);
		foreach (rows[k]) send_item(rows[k].it, rows[k].chk, rows[k].exp);

		// random instruction streams
		while (n_sent < N_ITEMS) begin
			if (n_sent > N_ITEMS / 3 && snd_idle == 25) begin
				snd_idle = 57; rcv_idle = 25;
			end
			if (n_sent > 2 * N_ITEMS / 3 && snd_idle != 0) begin
				snd_idle = 0; rcv_idle = 0;
			end
			if (n_sent > 300 && n_sent < 310) hold_req = 1'b1;
			if (n_sent > 900 && n_sent < 910) begin
				// pause until the core has drained
				item_valid <= 1'b0;
				wait (expected_q.size() == 0);
				@(negedge clk);
			end
			if (m_await) begin
				if ($urandom_range(3) == 0) run_step();
				else random_misc();
			end else if ($urandom_range(99) < 70) begin
				random_insn();
			end else begin
				random_misc();
			end
		end

		// halting tail: one of the three halt causes
		v = $urandom_range(2);
		tail_pc = m_pc;
		if (m_await) begin
			send_item('{op: wmc_pkg::OP_PORT, addr: 16'h0, data: 16'h0});
		end
		if (v == 0) begin
			load_code(m_pc, {8'($urandom), wmc_pkg::OC_HALT});
		end else if (v == 1) begin
			load_code(m_pc, {8'($urandom), 8'($urandom_range(8'h1D, 8'hFE))});
		end else begin
			// jump close to the top, then issue an in that crosses the guard
			tail_pc = m_pc;
			load_code(tail_pc, {wmc_pkg::MD_IMM, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_JZ});
			load_code(tail_pc + 16'd1, 16'(wmc_pkg::MEM_WORDS - wmc_pkg::PC_GUARD - 2));
			load_code(tail_pc + 16'd2, 16'h0000);
			run_step();
			tail_pc = m_pc;
			load_code(tail_pc, {wmc_pkg::MD_DIR, wmc_pkg::MD_IMM, 4'h0, wmc_pkg::OC_IN});
			load_code(tail_pc + 16'd1, 16'h0030);
			load_code(tail_pc + 16'd2, 16'h00AA);
		end
		run_step();
		send_item('{op: wmc_pkg::OP_PORT, addr: 16'h0, data: 16'h7777});
		run_step();
		send_item('{op: wmc_pkg::OP_READ, addr: 16'h0030, data: 16'h0});
		run_step();

		item_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d transactions, %0d instructions executed, %0d results checked",
			n_sent, n_insn, n_recv);
		$display("Port writes %0d, port requests %0d, divide-by-zero %0d, halt cause %0d",
			n_pwr, n_preq, n_divz, m_hcause);
		if (n_err == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
